[rtl/sdq_pkg.sv]
package sdq_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned TAG_BITS     = 8;
  localparam int unsigned IN_TIME_BITS = 8;
  localparam int unsigned OCC_BITS     = 5;

  // Operation codes carried on in_operation.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } sdq_op_t;

  // Per-cell control broadcast from the top level.
  typedef struct packed {
    logic insert;  // a job is being placed somewhere in the row
    logic pop;     // the head leaves, every cell takes its right neighbour
    logic dec;     // the head's time counts down by one (head cell only)
  } sdq_ctrl_t;

endpackage

[rtl/sdq_cell.sv]
module sdq_cell #(
  parameter int unsigned TIME_BITS = 8
) (
  input  logic                          clk,
  input  sdq_pkg::sdq_ctrl_t            ctrl,
  input  logic                          occupied,
  input  logic                          left_gt,
  input  logic [TIME_BITS-1:0]          new_time,
  input  logic [sdq_pkg::TAG_BITS-1:0]  new_tag,
  input  logic [TIME_BITS-1:0]          left_time,
  input  logic [sdq_pkg::TAG_BITS-1:0]  left_tag,
  input  logic [TIME_BITS-1:0]          right_time,
  input  logic [sdq_pkg::TAG_BITS-1:0]  right_tag,
  output logic                          gt,
  output logic [TIME_BITS-1:0]          time_out,
  output logic [sdq_pkg::TAG_BITS-1:0]  tag_out
);

  logic [TIME_BITS-1:0]         time_r, time_nxt;
  logic [sdq_pkg::TAG_BITS-1:0] tag_r, tag_nxt;

  // An empty cell, or one holding a later time, lies behind the new job.
  assign gt = !occupied || (time_r > new_time);

  always_comb begin
    time_nxt = time_r;
    tag_nxt  = tag_r;
    if (ctrl.insert && gt) begin
      if (left_gt) begin
        time_nxt = left_time;
        tag_nxt  = left_tag;
      end else begin
        time_nxt = new_time;
        tag_nxt  = new_tag;
      end
    end else if (ctrl.pop) begin
      time_nxt = right_time;
      tag_nxt  = right_tag;
    end else if (ctrl.dec) begin
      time_nxt = time_r - TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    tag_r  <= tag_nxt;
  end

  assign time_out = time_r;
  assign tag_out  = tag_r;

endmodule

[rtl/sorted_countdown_queue.sv]
// Sorted countdown queue. Holds up to DEPTH jobs, each a tag and a remaining
// time, in a row of cells ordered by ascending time with the head in cell 0.
// An insert request is placed behind every held job of equal or lower time,
// so equal times keep their arrival order; all cells compare against the new
// time at once and the later ones shift one place right. A tick request acts
// on the head alone: if its time is at most one it leaves the row, its tag is
// reported with out_ready_res set and the row shifts left, otherwise its time
// counts down by one. An insert into a full queue is discarded and flagged on
// out_dropped. Every request yields exactly one result carrying the occupancy
// after it. A new request is taken every cycle while the result register is
// free or being emptied. No clearing pass follows reset.
module sorted_countdown_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [sdq_pkg::TAG_BITS-1:0]      in_job_tag,
  input  logic [sdq_pkg::IN_TIME_BITS-1:0]  in_job_time,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ready_res,
  output logic [sdq_pkg::TAG_BITS-1:0]      out_ready_tag,
  output logic                              out_dropped,
  output logic [sdq_pkg::OCC_BITS-1:0]      out_occupancy
);

  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  // Job count, which also tells each cell whether it holds a job.
  logic [CNT_BITS-1:0] count_r, count_nxt;

  // Result register, separating the two handshakes.
  logic                         out_valid_r;
  logic                         ready_res_r;
  logic [sdq_pkg::TAG_BITS-1:0] ready_tag_r;
  logic                         dropped_r;
  logic [sdq_pkg::OCC_BITS-1:0] occupancy_r;

  logic                         accept;
  logic                         is_insert;
  logic                         is_tick;
  logic                         full;
  logic                         head_done;
  logic                         do_insert;
  logic                         do_pop;
  logic                         do_dec;
  logic [TIME_BITS-1:0]         new_time;

  logic [DEPTH-1:0]             occ;
  logic [DEPTH-1:0]             gt;
  logic [TIME_BITS-1:0]         cell_time [DEPTH];
  logic [sdq_pkg::TAG_BITS-1:0] cell_tag  [DEPTH];

  // A request is taken whenever the result register is empty or drains now.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_insert = (sdq_pkg::sdq_op_t'(in_operation) == sdq_pkg::OP_INSERT);
  assign is_tick   = (sdq_pkg::sdq_op_t'(in_operation) == sdq_pkg::OP_TICK);
  assign full      = (count_r == CNT_BITS'(DEPTH));

  // The low TIME_BITS bits of the requested time are kept.
  assign new_time = TIME_BITS'(in_job_time);

  // The head is finished when its time has reached one or zero.
  assign head_done = (cell_time[0] <= TIME_BITS'(1));

  assign do_insert = accept && is_insert && !full;
  assign do_pop    = accept && is_tick && (count_r != '0) && head_done;
  assign do_dec    = accept && is_tick && (count_r != '0) && !head_done;

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  // The row of cells. Cell 0 is the head and alone sees the countdown.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdq_pkg::sdq_ctrl_t ctrl;

    assign occ[i]      = (CNT_BITS'(i) < count_r);
    assign ctrl.insert = do_insert;
    assign ctrl.pop    = do_pop;
    assign ctrl.dec    = (i == 0) ? do_dec : 1'b0;

    sdq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ[i]),
      .left_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .new_time   (new_time),
      .new_tag    (in_job_tag),
      .left_time  (cell_time[(i == 0) ? 0 : i - 1]),
      .left_tag   (cell_tag[(i == 0) ? 0 : i - 1]),
      .right_time (cell_time[(i == DEPTH - 1) ? i : i + 1]),
      .right_tag  (cell_tag[(i == DEPTH - 1) ? i : i + 1]),
      .gt         (gt[i]),
      .time_out   (cell_time[i]),
      .tag_out    (cell_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ready_res_r <= do_pop;
      ready_tag_r <= do_pop ? cell_tag[0] : '0;
      dropped_r   <= is_insert && full;
      occupancy_r <= sdq_pkg::OCC_BITS'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ready_res = ready_res_r;
  assign out_ready_tag = ready_tag_r;
  assign out_dropped   = dropped_r;
  assign out_occupancy = occupancy_r;

endmodule
